[sv/cmv_pkg.sv]
package cmv_pkg;

    localparam int DEF_MAX_SLICES = 256;
    localparam int DEF_MAX_STACKS = 256;
    localparam int DEF_PHASE_BITS = 16;

    localparam int CORDIC_STEPS = 20;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [15:0] RADIUS_RESET = 16'd256;
    localparam logic [15:0] HEIGHT_RESET = 16'd512;
    localparam logic [8:0]  SLICES_RESET = 9'd16;
    localparam logic [8:0]  STACKS_RESET = 9'd2;

    typedef enum logic [1:0] {
        REG_RADIUS = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_SLICES = 2'd2,
        REG_STACKS = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        K_TOP    = 2'd0,
        K_BODY   = 2'd1,
        K_BOTTOM = 2'd2,
        K_QUAD   = 2'd3
    } t_kind;

    // sideband carried alongside the dividers
    typedef struct packed {
        t_kind       kind;
        logic        neg;
        logic [15:0] idx_a;
        logic [15:0] idx_b;
        logic [15:0] idx_c;
        logic [15:0] idx_d;
    } t_sb1;

    // sideband carried alongside the CORDIC
    typedef struct packed {
        t_kind              kind;
        logic signed [16:0] pos_y;
        logic [15:0]        idx_a;
        logic [15:0]        idx_b;
        logic [15:0]        idx_c;
        logic [15:0]        idx_d;
    } t_sb2;

    // arctan(2^-i) in units of 2^32 per turn
    function automatic logic [31:0] step_angle(input int i);
        logic [31:0] a;
        case (i)
            0:  a = 32'h20000000;
            1:  a = 32'h12E4051E;
            2:  a = 32'h09FB385B;
            3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;
            5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;
            7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;
            9:  a = 32'h00145F2F;
            10: a = 32'h000A2F98;
            11: a = 32'h000517CC;
            12: a = 32'h00028BE6;
            13: a = 32'h000145F3;
            14: a = 32'h0000A2FA;
            15: a = 32'h0000517D;
            16: a = 32'h000028BE;
            17: a = 32'h0000145F;
            18: a = 32'h00000A30;
            19: a = 32'h00000518;
            default: a = 32'h0;
        endcase
        return a;
    endfunction

endpackage

[sv/cmv_div.sv]
module cmv_div import cmv_pkg::*; #(
    parameter int NW = 28,
    parameter int DW = 10
) (
    input  logic          i_clk,
    input  logic          i_adv,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_quo
);

    // one quotient bit per stage, restoring; upper DW bits hold the remainder
    logic [DW+NW-1:0] r_acc [NW];
    logic [DW-1:0]    r_den [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DW+NW-1:0] w_acc;
        logic [DW-1:0]    w_den;
        logic [DW:0]      w_t;
        logic [DW:0]      w_r;
        logic             w_ge;

        if (k == 0) begin : g_first
            assign w_acc = {{DW{1'b0}}, i_num};
            assign w_den = i_den;
        end else begin : g_next
            assign w_acc = r_acc[k-1];
            assign w_den = r_den[k-1];
        end

        assign w_t  = w_acc[DW+NW-1:NW-1];
        assign w_ge = (w_t >= {1'b0, w_den});
        assign w_r  = w_ge ? (w_t - {1'b0, w_den}) : w_t;

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_acc[k] <= {w_r[DW-1:0], w_acc[NW-2:0], w_ge};
                r_den[k] <= w_den;
            end
        end
    end

    assign o_quo = r_acc[NW-1][NW-1:0];

endmodule

[sv/cmv_cordic.sv]
module cmv_cordic import cmv_pkg::*; #(
    parameter int PHASE_BITS = DEF_PHASE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_adv,
    input  logic [PHASE_BITS-1:0] i_phase,
    output logic signed [15:0]    o_cos,
    output logic signed [15:0]    o_sin
);

    logic [31:0]        w_p32;
    logic signed [33:0] r_x [CORDIC_STEPS];
    logic signed [33:0] r_y [CORDIC_STEPS];
    logic signed [32:0] r_z [CORDIC_STEPS];
    logic [1:0]         r_q [CORDIC_STEPS];
    logic signed [15:0] r_cos;
    logic signed [15:0] r_sin;
    logic signed [15:0] w_cc;
    logic signed [15:0] w_ss;

    assign w_p32 = {i_phase, {(32-PHASE_BITS){1'b0}}};

    function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
        logic signed [33:0] t;
        t = (v + 34'sd32768) >>> 16;
        if (t > 34'sd16384) begin
            t = 34'sd16384;
        end else if (t < -34'sd16384) begin
            t = -34'sd16384;
        end
        return t[15:0];
    endfunction

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [33:0] w_x;
        logic signed [33:0] w_y;
        logic signed [32:0] w_z;
        logic [1:0]         w_q;

        if (i == 0) begin : g_first
            assign w_x = CORDIC_GAIN;
            assign w_y = '0;
            assign w_z = {3'b000, w_p32[29:0]};
            assign w_q = w_p32[31:30];
        end else begin : g_next
            assign w_x = r_x[i-1];
            assign w_y = r_y[i-1];
            assign w_z = r_z[i-1];
            assign w_q = r_q[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                if (!w_z[32]) begin
                    r_x[i] <= w_x - (w_y >>> i);
                    r_y[i] <= w_y + (w_x >>> i);
                    r_z[i] <= w_z - $signed({1'b0, step_angle(i)});
                end else begin
                    r_x[i] <= w_x + (w_y >>> i);
                    r_y[i] <= w_y - (w_x >>> i);
                    r_z[i] <= w_z + $signed({1'b0, step_angle(i)});
                end
                r_q[i] <= w_q;
            end
        end
    end

    assign w_cc = to_q14(r_x[CORDIC_STEPS-1]);
    assign w_ss = to_q14(r_y[CORDIC_STEPS-1]);

    // unfold the quadrant
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            case (r_q[CORDIC_STEPS-1])
                2'd0: begin
                    r_cos <= w_cc;
                    r_sin <= w_ss;
                end
                2'd1: begin
                    r_cos <= -w_ss;
                    r_sin <= w_cc;
                end
                2'd2: begin
                    r_cos <= -w_cc;
                    r_sin <= -w_ss;
                end
                default: begin
                    r_cos <= w_ss;
                    r_sin <= -w_cc;
                end
            endcase
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

[sv/cylinder_mesh_vertex_generator.sv]
// Channel   Direction  Handshake          Word
// request   in         i_valid / o_stall  kind, slice number, stack number
// vertex    out        o_valid / i_stall  position, normal, texture, indices
// config    in         APB, pready high   radius, height, slice and stack count
//
// One word enters per cycle while o_stall is low; the word passes stage 0, stage 1,
// the bit-per-stage dividers (NW stages), the 20-stage CORDIC and the output stage.
// The whole pipeline advances together; a stalled output word freezes every
// stage and raises o_stall on the request side in the same cycle.
// Reset is synchronous, clears the valid bits and loads the default configuration.
module cylinder_mesh_vertex_generator import cmv_pkg::*; #(
    parameter int MAX_SLICES = DEF_MAX_SLICES,
    parameter int MAX_STACKS = DEF_MAX_STACKS,
    parameter int PHASE_BITS = DEF_PHASE_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_kind,
    input  logic [7:0]         i_slice_number,
    input  logic [7:0]         i_stack_number,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [16:0] o_pos_x,
    output logic signed [16:0] o_pos_y,
    output logic signed [16:0] o_pos_z,
    output logic signed [15:0] o_norm_x,
    output logic signed [15:0] o_norm_y,
    output logic signed [15:0] o_norm_z,
    output logic signed [15:0] o_tex_u,
    output logic signed [15:0] o_tex_v,
    output logic [15:0]        o_index_a,
    output logic [15:0]        o_index_b,
    output logic [15:0]        o_index_c,
    output logic [15:0]        o_index_d,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int SW  = $clog2(MAX_SLICES + 1);
    localparam int TW  = $clog2(MAX_STACKS + 1);
    localparam int NWA = ((PHASE_BITS + 8 > SW) ? PHASE_BITS + 8 : SW) + 1;
    localparam int NWB = 16 + TW + 1;
    localparam int NW  = (NWA > NWB) ? NWA : NWB;
    localparam int DW  = (SW > TW + 1) ? SW : TW + 1;
    localparam int QW  = (SW + 10 > 17) ? SW + 10 : 17;
    localparam int CL  = CORDIC_STEPS + 1;

    // configuration registers
    logic [15:0] r_radius;
    logic [15:0] r_height;
    logic [8:0]  r_slice_count;
    logic [8:0]  r_stack_count;
    t_reg        w_reg;

    // pipeline control
    logic        w_adv;

    // effective counts, to be kept stable by the user while words are in flight; the block does not enforce it
    logic [SW-1:0] w_s;
    logic [TW-1:0] w_t;

    // stage 0: saturated request
    logic        r0_valid;
    t_kind       r0_kind;
    logic [7:0]  r0_sl;
    logic [7:0]  r0_st;
    logic [7:0]  w0_sl;
    logic [7:0]  w0_st;

    // stage 1: numerators and indices
    logic          r1_valid;
    t_sb1          r1_sb;
    logic [NW-1:0] r1_num_a;
    logic [DW-1:0] r1_den_a;
    logic [NW-1:0] r1_num_b;
    logic [DW-1:0] r1_den_b;
    t_sb1          w1_sb;
    logic [NW-1:0] w1_num_a;
    logic [NW-1:0] w1_num_b;
    logic [DW-1:0] w1_den_b;

    // divider and CORDIC sideband lines
    logic          r_d_valid [NW];
    t_sb1          r_d_sb    [NW];
    logic          r_c_valid [CL];
    t_sb2          r_c_sb    [CL];
    logic [NW-1:0] w_quo_a;
    logic [NW-1:0] w_quo_b;
    t_sb2          w2_sb;
    logic signed [15:0] w_cos;
    logic signed [15:0] w_sin;

    // output stage
    logic               r_out_valid;
    t_kind              r_out_kind;
    logic signed [16:0] r_pos_x;
    logic signed [16:0] r_pos_y;
    logic signed [16:0] r_pos_z;
    logic signed [15:0] r_norm_x;
    logic signed [15:0] r_norm_y;
    logic signed [15:0] r_norm_z;
    logic signed [15:0] r_tex_u;
    logic signed [15:0] r_tex_v;
    logic [15:0]        r_idx_a;
    logic [15:0]        r_idx_b;
    logic [15:0]        r_idx_c;
    logic [15:0]        r_idx_d;
    logic signed [32:0] w_prx;
    logic signed [32:0] w_prz;
    logic signed [32:0] w_rx;
    logic signed [32:0] w_rz;
    logic signed [15:0] w_nsin;
    logic signed [15:0] w_tu;
    logic signed [15:0] w_tv;

    function automatic logic [15:0] f_sat16(input logic [QW-1:0] v);
        return (v > QW'(65535)) ? 16'hFFFF : v[15:0];
    endfunction

    // ---------------------------------------------------------------- config
    assign pready = 1'b1;
    assign w_reg  = t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius      <= RADIUS_RESET;
            r_height      <= HEIGHT_RESET;
            r_slice_count <= SLICES_RESET;
            r_stack_count <= STACKS_RESET;
        end else if (psel && penable && pwrite) begin
            case (w_reg)
                REG_RADIUS: r_radius      <= pwdata[15:0];
                REG_HEIGHT: r_height      <= pwdata[15:0];
                REG_SLICES: r_slice_count <= pwdata[8:0];
                REG_STACKS: r_stack_count <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_RADIUS: prdata = {16'd0, r_radius};
            REG_HEIGHT: prdata = {16'd0, r_height};
            REG_SLICES: prdata = {23'd0, r_slice_count};
            REG_STACKS: prdata = {23'd0, r_stack_count};
            default:    prdata = '0;
        endcase
    end

    // clamp the counts to the supported range
    always_comb begin
        int v_s;
        int v_t;
        v_s = int'(r_slice_count);
        v_t = int'(r_stack_count);
        if (v_s < 3) begin
            v_s = 3;
        end else if (v_s > MAX_SLICES) begin
            v_s = MAX_SLICES;
        end
        if (v_t < 2) begin
            v_t = 2;
        end else if (v_t > MAX_STACKS) begin
            v_t = MAX_STACKS;
        end
        w_s = SW'(v_s);
        w_t = TW'(v_t);
    end

    // -------------------------------------------------------------- control
    // hold every stage while the output word waits
    assign w_adv   = !(r_out_valid && i_stall);
    assign o_stall = r_out_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid    <= 1'b0;
            r1_valid    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NW; k++) begin
                r_d_valid[k] <= 1'b0;
            end
            for (int k = 0; k < CL; k++) begin
                r_c_valid[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r0_valid     <= i_valid;
            r1_valid     <= r0_valid;
            r_d_valid[0] <= r1_valid;
            for (int k = 1; k < NW; k++) begin
                r_d_valid[k] <= r_d_valid[k-1];
            end
            r_c_valid[0] <= r_d_valid[NW-1];
            for (int k = 1; k < CL; k++) begin
                r_c_valid[k] <= r_c_valid[k-1];
            end
            r_out_valid  <= r_c_valid[CL-1];
        end
    end

    // -------------------------------------------------------------- stage 0
    // saturate the slice and stack numbers
    always_comb begin
        int v_lim;
        if (int'(i_slice_number) > int'(w_s) - 1) begin
            w0_sl = 8'(int'(w_s) - 1);
        end else begin
            w0_sl = i_slice_number;
        end
        v_lim = (t_kind'(i_kind) == K_QUAD) ? int'(w_t) - 2 : int'(w_t) - 1;
        if (int'(i_stack_number) > v_lim) begin
            w0_st = 8'(v_lim);
        end else begin
            w0_st = i_stack_number;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_kind <= t_kind'(i_kind);
            r0_sl   <= w0_sl;
            r0_st   <= w0_st;
        end
    end

    // -------------------------------------------------------------- stage 1
    always_comb begin
        int                v_n;
        logic              v_neg;
        logic [TW-1:0]     v_abs;
        logic [15+TW:0]    v_mag;
        logic [SW+7:0]     v_base;
        logic [SW-1:0]     v_nxt;
        logic [QW-1:0]     v_a;
        logic [QW-1:0]     v_d;

        // phase = round(sl * 2^PHASE_BITS / S)
        w1_num_a = (NW'(r0_sl) << PHASE_BITS) + NW'(w_s >> 1);

        // body height = round(h * |T-1-2*st| / (2*(T-1)))
        v_n      = int'(w_t) - 1 - 2 * int'(r0_st);
        v_neg    = (v_n < 0);
        v_abs    = TW'(v_neg ? -v_n : v_n);
        v_mag    = (16+TW)'(r_height) * (16+TW)'(v_abs);
        w1_num_b = NW'(v_mag) + NW'(int'(w_t) - 1);
        w1_den_b = DW'(2 * (int'(w_t) - 1));

        // quad corners, wrapping at the last slice
        v_base = (SW+8)'(w_s) * (SW+8)'(r0_st);
        v_nxt  = (int'(r0_sl) == int'(w_s) - 1) ? '0 : SW'(int'(r0_sl) + 1);
        v_a    = QW'(v_base) + QW'(r0_sl);
        v_d    = QW'(v_base) + QW'(v_nxt);

        w1_sb.kind  = r0_kind;
        w1_sb.neg   = v_neg;
        w1_sb.idx_a = '0;
        w1_sb.idx_b = '0;
        w1_sb.idx_c = '0;
        w1_sb.idx_d = '0;
        case (r0_kind)
            K_TOP:    w1_sb.idx_a = 16'(r0_sl);
            K_BOTTOM: w1_sb.idx_a = 16'(int'(w_s) - 1 - int'(r0_sl));
            K_QUAD: begin
                w1_sb.idx_a = f_sat16(v_a);
                w1_sb.idx_b = f_sat16(v_a + QW'(w_s));
                w1_sb.idx_c = f_sat16(v_d + QW'(w_s));
                w1_sb.idx_d = f_sat16(v_d);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_sb    <= w1_sb;
            r1_num_a <= w1_num_a;
            r1_den_a <= DW'(w_s);
            r1_num_b <= w1_num_b;
            r1_den_b <= w1_den_b;
        end
    end

    // ------------------------------------------------------------- dividers
    cmv_div #(
        .NW (NW),
        .DW (DW)
    ) u_div_phase (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_num (r1_num_a),
        .i_den (r1_den_a),
        .o_quo (w_quo_a)
    );

    cmv_div #(
        .NW (NW),
        .DW (DW)
    ) u_div_height (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_num (r1_num_b),
        .i_den (r1_den_b),
        .o_quo (w_quo_b)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d_sb[0] <= r1_sb;
            for (int k = 1; k < NW; k++) begin
                r_d_sb[k] <= r_d_sb[k-1];
            end
        end
    end

    // vertex height, resolved as the word enters the CORDIC
    always_comb begin
        logic signed [16:0] v_cap;
        logic signed [16:0] v_body;
        v_cap  = $signed({1'b0, 16'(({1'b0, r_height} + 17'd1) >> 1)});
        v_body = $signed({1'b0, w_quo_b[15:0]});
        w2_sb.kind  = r_d_sb[NW-1].kind;
        w2_sb.idx_a = r_d_sb[NW-1].idx_a;
        w2_sb.idx_b = r_d_sb[NW-1].idx_b;
        w2_sb.idx_c = r_d_sb[NW-1].idx_c;
        w2_sb.idx_d = r_d_sb[NW-1].idx_d;
        case (r_d_sb[NW-1].kind)
            K_TOP:    w2_sb.pos_y = v_cap;
            K_BOTTOM: w2_sb.pos_y = -v_cap;
            K_BODY:   w2_sb.pos_y = r_d_sb[NW-1].neg ? -v_body : v_body;
            default:  w2_sb.pos_y = '0;
        endcase
    end

    // --------------------------------------------------------------- CORDIC
    cmv_cordic #(
        .PHASE_BITS (PHASE_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_adv   (w_adv),
        .i_phase (w_quo_a[PHASE_BITS-1:0]),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_sb[0] <= w2_sb;
            for (int k = 1; k < CL; k++) begin
                r_c_sb[k] <= r_c_sb[k-1];
            end
        end
    end

    // --------------------------------------------------------- output stage
    assign w_nsin = -w_sin;
    assign w_prx  = $signed({1'b0, r_radius}) * w_cos;
    assign w_prz  = $signed({1'b0, r_radius}) * w_nsin;
    assign w_rx   = (w_prx + 33'sd8192) >>> 14;
    assign w_rz   = (w_prz + 33'sd8192) >>> 14;
    assign w_tu   = (w_cos + 16'sd2) >>> 2;
    assign w_tv   = (w_sin + 16'sd2) >>> 2;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_kind <= r_c_sb[CL-1].kind;
            r_idx_a    <= r_c_sb[CL-1].idx_a;
            r_idx_b    <= r_c_sb[CL-1].idx_b;
            r_idx_c    <= r_c_sb[CL-1].idx_c;
            r_idx_d    <= r_c_sb[CL-1].idx_d;
            r_pos_y    <= r_c_sb[CL-1].pos_y;
            case (r_c_sb[CL-1].kind)
                K_TOP: begin
                    r_pos_x  <= w_rx[16:0];
                    r_pos_z  <= w_rz[16:0];
                    r_norm_x <= '0;
                    r_norm_y <= 16'sd16384;
                    r_norm_z <= '0;
                    r_tex_u  <= w_tu;
                    r_tex_v  <= w_tv;
                end
                K_BOTTOM: begin
                    r_pos_x  <= w_rx[16:0];
                    r_pos_z  <= w_rz[16:0];
                    r_norm_x <= '0;
                    r_norm_y <= -16'sd16384;
                    r_norm_z <= '0;
                    r_tex_u  <= 16'sd16384 - w_tu;
                    r_tex_v  <= 16'sd16384 - w_tv;
                end
                K_BODY: begin
                    r_pos_x  <= w_rx[16:0];
                    r_pos_z  <= w_rz[16:0];
                    r_norm_x <= w_cos;
                    r_norm_y <= '0;
                    r_norm_z <= w_nsin;
                    r_tex_u  <= w_tu;
                    r_tex_v  <= w_tv;
                end
                default: begin
                    r_pos_x  <= '0;
                    r_pos_z  <= '0;
                    r_norm_x <= '0;
                    r_norm_y <= '0;
                    r_norm_z <= '0;
                    r_tex_u  <= '0;
                    r_tex_v  <= '0;
                end
            endcase
        end
    end

    assign o_valid   = r_out_valid;
    assign o_pos_x   = r_pos_x;
    assign o_pos_y   = r_pos_y;
    assign o_pos_z   = r_pos_z;
    assign o_norm_x  = r_norm_x;
    assign o_norm_y  = r_norm_y;
    assign o_norm_z  = r_norm_z;
    assign o_tex_u   = r_tex_u;
    assign o_tex_v   = r_tex_v;
    assign o_index_a = r_idx_a;
    assign o_index_b = r_idx_b;
    assign o_index_c = r_idx_c;
    assign o_index_d = r_idx_d;

    // ------------------------------------------------------------ assertions
    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("request stalled with no word waiting");

    a_advance_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r0_valid && !o_stall) |=> r1_valid)
        else $error("word lost between stage 0 and stage 1");

    a_quad_no_geometry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_out_kind == K_QUAD) |->
        (o_pos_x == 0 && o_pos_y == 0 && o_norm_y == 0 && o_tex_u == 0))
        else $error("quad word carries geometry");

    a_vertex_indices: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_out_kind != K_QUAD) |->
        (o_index_b == 0 && o_index_c == 0 && o_index_d == 0))
        else $error("vertex word carries quad indices");

    a_top_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_out_kind == K_TOP) |->
        (o_norm_y == 16'sd16384 && o_pos_y >= 0))
        else $error("top cap vertex with wrong normal or height");

endmodule

[dv/tb.sv]
module tb;
    import cmv_pkg::*;

    // one vertex word as it leaves the block
    typedef struct packed {
        logic signed [16:0] pos_x;
        logic signed [16:0] pos_y;
        logic signed [16:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic signed [15:0] tex_u;
        logic signed [15:0] tex_v;
        logic [15:0]        index_a;
        logic [15:0]        index_b;
        logic [15:0]        index_c;
        logic [15:0]        index_d;
    } vertex_t;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] slice;
        logic [7:0] stack;
    } request_t;

    localparam int SLICE_MAX  = 256;
    localparam int STACK_MAX  = 256;
    localparam int PH_BITS    = 16;
    localparam int SETTLE     = 100;
    localparam int CYCLE_CAP  = 400000;

    // arctan(2^-i), 2^32 per turn
    localparam longint ATAN_TAB [0:19] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_kind = 2'd0;
    logic [7:0]         i_slice_number = 8'd0;
    logic [7:0]         i_stack_number = 8'd0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [16:0] o_pos_x, o_pos_y, o_pos_z;
    logic signed [15:0] o_norm_x, o_norm_y, o_norm_z, o_tex_u, o_tex_v;
    logic [15:0]        o_index_a, o_index_b, o_index_c, o_index_d;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = 4'd0;
    logic [31:0]        pwdata = 32'd0;
    logic [31:0]        prdata;
    logic               pready;

    cylinder_mesh_vertex_generator DUT (.*);

    // shadow of the configuration registers
    logic [15:0] cfg_radius = RADIUS_RESET;
    logic [15:0] cfg_height = HEIGHT_RESET;
    logic [8:0]  cfg_slices = SLICES_RESET;
    logic [8:0]  cfg_stacks = STACKS_RESET;

    request_t request_q [$];
    vertex_t  vertex_q  [$];
    int       mismatches = 0;
    int       cycles = 0;
    bit       hold_off = 0;
    bit       calm = 0;
    bit       req_taken = 0;
    bit       word_taken = 0;
    int       gap_left = 0;
    int       stall_left = 0;

    initial forever #2 i_clk = ~i_clk;

    function automatic longint q14(longint v30);
        longint r;
        r = (v30 + 64'sd32768) >>> 16;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r;
    endfunction

    // cosine and sine of a phase, Q1.14
    function automatic void rotate(input logic [15:0] ph, output longint c,
                                   output longint s);
        logic [31:0] p32;
        longint x, y, z, dx, dy, cc, ss;
        p32 = {ph, 16'd0};
        x = CORDIC_GAIN;
        y = 0;
        z = longint'(p32[29:0]);
        for (int i = 0; i < 20; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TAB[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TAB[i];
            end
        end
        cc = q14(x);
        ss = q14(y);
        case (p32[31:30])
            2'd0: begin c = cc;  s = ss;  end
            2'd1: begin c = -ss; s = cc;  end
            2'd2: begin c = -cc; s = -ss; end
            default: begin c = ss; s = -cc; end
        endcase
    endfunction

    function automatic vertex_t tessellate(request_t rq);
        vertex_t v;
        longint nS, nT, sl, st, base, nxt, ph, c, s, n, mag, den, py, tu, tv;
        v = '0;
        nS = cfg_slices;
        nT = cfg_stacks;
        if (nS < 3) nS = 3;
        if (nS > SLICE_MAX) nS = SLICE_MAX;
        if (nT < 2) nT = 2;
        if (nT > STACK_MAX) nT = STACK_MAX;
        sl = rq.slice;
        st = rq.stack;
        if (sl > nS - 1) sl = nS - 1;
        if (rq.kind == K_QUAD) begin
            if (st > nT - 2) st = nT - 2;
            base = nS * st;
            nxt = (sl == nS - 1) ? 0 : sl + 1;
            v.index_a = (base + sl > 65535) ? 16'hFFFF : 16'(base + sl);
            v.index_b = (base + sl + nS > 65535) ? 16'hFFFF : 16'(base + sl + nS);
            v.index_c = (base + nxt + nS > 65535) ? 16'hFFFF : 16'(base + nxt + nS);
            v.index_d = (base + nxt > 65535) ? 16'hFFFF : 16'(base + nxt);
            return v;
        end
        ph = ((sl << PH_BITS) + nS / 2) / nS;
        rotate(16'(ph), c, s);
        v.pos_x = 17'((longint'(cfg_radius) * c + 8192) >>> 14);
        v.pos_z = 17'((longint'(cfg_radius) * (-s) + 8192) >>> 14);
        tu = (c + 2) >>> 2;
        tv = (s + 2) >>> 2;
        case (rq.kind)
            K_TOP: begin
                v.pos_y = 17'((cfg_height + 17'd1) >> 1);
                v.norm_y = 16'sd16384;
                v.index_a = 16'(sl);
            end
            K_BOTTOM: begin
                v.pos_y = -17'((cfg_height + 17'd1) >> 1);
                v.norm_y = -16'sd16384;
                tu = 16384 - tu;
                tv = 16384 - tv;
                v.index_a = 16'(nS - 1 - sl);
            end
            default: begin
                if (st > nT - 1) st = nT - 1;
                n = nT - 1 - 2 * st;
                mag = longint'(cfg_height) * (n < 0 ? -n : n);
                den = 2 * (nT - 1);
                py = (mag + den / 2) / den;
                v.pos_y = 17'(n < 0 ? -py : py);
                v.norm_x = 16'(c);
                v.norm_z = 16'(-s);
            end
        endcase
        v.tex_u = 16'(tu);
        v.tex_v = 16'(tv);
        return v;
    endfunction

    // sample both channels at the rising edge
    always @(posedge i_clk) begin
        vertex_t got, want;
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (i_rst_n && i_valid && !o_stall) begin
            vertex_q.push_back(tessellate(request_t'({i_kind, i_slice_number,
                                                      i_stack_number})));
            req_taken = 1;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_pos_x, o_pos_y, o_pos_z, o_norm_x, o_norm_y, o_norm_z,
                   o_tex_u, o_tex_v, o_index_a, o_index_b, o_index_c, o_index_d};
            word_taken = 1;
            if (vertex_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected vertex word %p", got);
            end else begin
                want = vertex_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("vertex mismatch\n  expected %p\n  actual   %p",
                                 want, got);
                end
            end
        end
    end

    // request driver: drop valid once taken, then wait out the drawn gap
    always @(negedge i_clk) begin
        request_t rq;
        logic v;
        v = i_valid;
        if (req_taken) begin
            v = 0;
            req_taken = 0;
        end
        if (!v && i_rst_n) begin
            if (gap_left > 0) gap_left--;
            else if (!hold_off && request_q.size() > 0) begin
                rq = request_q.pop_front();
                i_kind <= rq.kind;
                i_slice_number <= rq.slice;
                i_stack_number <= rq.stack;
                v = 1;
                gap_left = calm ? 0 : $urandom_range(0, 4);
            end
        end
        i_valid <= v;
    end

    // vertex receiver: stall for a drawn number of cycles after each word
    always @(negedge i_clk) begin
        if (word_taken) begin
            word_taken = 0;
            stall_left = calm ? 0 : $urandom_range(0, 4);
        end
        i_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
    end

    task automatic write_reg(t_reg r, logic [31:0] d);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {r, 2'b00}; pwdata <= d;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (r)
            REG_RADIUS: cfg_radius = d[15:0];
            REG_HEIGHT: cfg_height = d[15:0];
            REG_SLICES: cfg_slices = d[8:0];
            default:    cfg_stacks = d[8:0];
        endcase
    endtask

    task automatic drain();
        do begin
            @(posedge i_clk);
            #1;
        end while (request_q.size() != 0 || i_valid || vertex_q.size() != 0);
    endtask

    task automatic configure(int r, int h, int sc, int tc);
        drain();
        repeat (SETTLE) @(posedge i_clk);
        write_reg(REG_RADIUS, r);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_SLICES, sc);
        write_reg(REG_STACKS, tc);
    endtask

    task automatic push(t_kind k, int sl, int st);
        request_q.push_back('{k, 8'(sl), 8'(st)});
    endtask

    // mostly in-range slice and stack numbers, some saturating noise
    task automatic random_items(int count);
        int sc, tc;
        sc = (cfg_slices < 3) ? 3 : (cfg_slices > 256 ? 256 : cfg_slices);
        tc = (cfg_stacks < 2) ? 2 : (cfg_stacks > 256 ? 256 : cfg_stacks);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) < 7)
                push(t_kind'($urandom_range(0, 3)), $urandom_range(0, sc - 1),
                     $urandom_range(0, tc - 1));
            else
                push(t_kind'($urandom_range(0, 3)), $urandom_range(0, 255),
                     $urandom_range(0, 255));
        end
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1;

        // directed: every kind at the corners, reset configuration
        for (int k = 0; k < 4; k++) begin
            push(t_kind'(k), 0, 0);
            push(t_kind'(k), 15, 1);
            push(t_kind'(k), 255, 255);
        end
        push(K_BODY, 4, 0);
        push(K_QUAD, 7, 0);

        // largest mesh: quad indices reach 65535 near the top ring without saturating
        configure(65535, 65535, 256, 256);
        push(K_QUAD, 255, 254);
        push(K_QUAD, 255, 255);
        push(K_QUAD, 0, 254);
        push(K_BODY, 128, 255);
        push(K_BODY, 64, 127);
        push(K_TOP, 255, 0);
        push(K_BOTTOM, 255, 0);

        // counts below range clamp to the smallest mesh
        configure(0, 0, 0, 0);
        for (int k = 0; k < 4; k++) push(t_kind'(k), 2, 1);
        drain();

        // hold the sender off while twenty requests queue up, then release them
        hold_off = 1;
        random_items(20);
        drain_hold: repeat (SETTLE) @(posedge i_clk);
        hold_off = 0;

        configure(65535, 1, 511, 511);
        random_items(80);

        for (int p = 0; p < 8; p++) begin
            configure($urandom_range(0, 65535), $urandom_range(0, 65535),
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511)
                                                  : $urandom_range(3, 24),
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511)
                                                  : $urandom_range(2, 12));
            calm = (p % 3 == 2);
            random_items(80);
        end
        calm = 0;

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && vertex_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
